// File: rtl/swm_pkg.sv
// Shared constants and types for the sliding window maximum block.
package swm_pkg;

    // Width of one sample and of one result value
    localparam int VALUE_W = 32;

    // Width of the window size register
    localparam int WS_W = 7;

    // Default number of cells in the chain
    localparam int WINDOW_MAX_DEF = 64;

    // Window size after reset
    localparam logic [WS_W-1:0] WS_RESET = WS_W'(1);

    // Per-cycle command broadcast from the control logic to every cell
    typedef struct packed {
        logic                      commit;  // take the pending sample this cycle
        logic                      shift;   // take the state of the right neighbor
        logic                      clear;   // sample opens a new array: drop every entry
        logic signed [VALUE_W-1:0] sample;  // pending sample value
    } t_cell_ctrl;

endpackage

// File: rtl/swm_cell.sv
// One cell of the candidate chain: holds one queue entry and its age.
module swm_cell
    import swm_pkg::*;
#(
    parameter int AGE_W = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctrl                i_ctrl,
    input  logic                      i_left_kept,
    input  logic                      i_right_valid,
    input  logic signed [VALUE_W-1:0] i_right_value,
    input  logic [AGE_W-1:0]          i_right_age,
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [AGE_W-1:0]          o_age,
    output logic                      o_kept,
    output logic signed [VALUE_W-1:0] o_next_value
);

    logic                      r_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic [AGE_W-1:0]          r_age;
    logic                      n_valid;
    logic signed [VALUE_W-1:0] n_value;
    logic [AGE_W-1:0]          n_age;

    logic                      src_valid;
    logic signed [VALUE_W-1:0] src_value;
    logic [AGE_W-1:0]          src_age;
    logic                      kept;

    // Select own entry or the neighbor's when the front is popped
    always_comb begin
        if (i_ctrl.shift) begin
            src_valid = i_right_valid;
            src_value = i_right_value;
            src_age   = i_right_age;
        end else begin
            src_valid = r_valid;
            src_value = r_value;
            src_age   = r_age;
        end
    end

    // Keep an entry only while it stays above the newcomer
    assign kept = src_valid && !i_ctrl.clear && (src_value > i_ctrl.sample);

    // Next entry: survivor ages by one, first free slot takes the newcomer
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_age   = r_age;
        if (i_ctrl.commit) begin
            if (kept) begin
                n_valid = 1'b1;
                n_value = src_value;
                n_age   = src_age + AGE_W'(1);
            end else if (i_left_kept) begin
                n_valid = 1'b1;
                n_value = i_ctrl.sample;
                n_age   = AGE_W'(1);
            end else begin
                n_valid = 1'b0;
            end
        end else if (i_ctrl.shift) begin
            n_valid = src_valid;
            n_value = src_value;
            n_age   = src_age;
        end
    end

    // Hold the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_valid      = r_valid;
    assign o_value      = r_value;
    assign o_age        = r_age;
    assign o_kept       = kept;
    assign o_next_value = n_value;

endmodule

// File: rtl/sliding_window_maximum.sv
// Sliding window maximum over signed 32-bit samples, built on a chain of queue cells.
// Each accepted sample enters a chain of WINDOW_MAX cells that holds the candidate
// maxima in arrival order, front (oldest, largest) in cell 0. When a sample is taken,
// every cell compares its entry with the newcomer, the front entry leaves if it has
// aged out, and the newcomer lands in the first free cell. When more than one front
// entry has aged out at once (after the window is made smaller, or with a window
// size of 0), each further expired entry is popped alone before the sample is taken.
// The result register loads when the sample is taken, so with nothing to pop and a
// free output the sample passes the pending sample register and then the result
// register before its result is offered; it holds while the output is stalled. One
// more sample can be accepted while a result waits, and that sample is taken only
// once the waiting result has transferred. Window sizes above WINDOW_MAX act as
// WINDOW_MAX; a window size of 0 keeps the queue running but yields no results.
// Write the window size only while the block is idle.
module sliding_window_maximum
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [WS_W-1:0]           i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [VALUE_W-1:0] i_sample_value,
    input  logic                      i_first_sample,
    input  logic                      i_last_sample,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [VALUE_W-1:0] o_window_max,
    output logic                      o_last_result
);

    localparam int AGE_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (AGE_W > WS_W) ? AGE_W : WS_W;

    // Configuration
    logic [WS_W-1:0]  r_window_size;
    logic [CMP_W-1:0] ws_ext;
    logic [CMP_W-1:0] w_eff;

    // Pending sample
    logic                      r_busy;
    logic signed [VALUE_W-1:0] r_sample;
    logic                      r_first;
    logic                      r_last;

    // Array progress
    logic [VALUE_W-1:0] r_pos;
    logic               r_full;
    logic [VALUE_W-1:0] pos;
    logic               produce;

    // Result register
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_max;
    logic                      r_out_last;

    // Chain signals
    logic                      c_valid      [WINDOW_MAX];
    logic signed [VALUE_W-1:0] c_value      [WINDOW_MAX];
    logic [AGE_W-1:0]          c_age        [WINDOW_MAX];
    logic                      c_kept       [WINDOW_MAX];
    logic signed [VALUE_W-1:0] c_next_value [WINDOW_MAX];

    t_cell_ctrl ctrl;
    logic       out_free;
    logic       expired0;
    logic       expired1;
    logic       do_commit;
    logic       do_shift;
    logic       accept;

    // Clamp the window size to the chain length
    assign ws_ext = CMP_W'(r_window_size);
    assign w_eff  = (ws_ext > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : ws_ext;

    // Front expiry checks
    assign expired0 = c_valid[0] && (CMP_W'(c_age[0]) >= w_eff);

    if (WINDOW_MAX > 1) begin : g_exp1
        assign expired1 = c_valid[1] && (CMP_W'(c_age[1]) >= w_eff);
    end else begin : g_exp1_none
        assign expired1 = 1'b1;
    end

    // Commit (output free) if at most the front leaves or an array opens; else pop it
    assign out_free  = !r_out_valid || !i_out_stall;
    assign do_commit = r_busy && out_free && (r_first || !expired0 || !expired1);
    assign do_shift  = r_busy && !r_first && expired0;

    assign ctrl.commit = do_commit;
    assign ctrl.shift  = do_shift;
    assign ctrl.clear  = r_first;
    assign ctrl.sample = r_sample;

    assign o_in_stall = r_busy && !do_commit;
    assign accept     = i_in_valid && !o_in_stall;

    // Position and result decision for the committed sample
    assign pos     = r_first ? '0 : r_pos;
    assign produce = (w_eff != '0)
                     && ((!r_first && r_full) || (pos >= (VALUE_W'(w_eff) - VALUE_W'(1))));

    // Build the cell chain
    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        logic                      right_valid;
        logic signed [VALUE_W-1:0] right_value;
        logic [AGE_W-1:0]          right_age;
        logic                      left_kept;

        if (k < WINDOW_MAX - 1) begin : g_right
            assign right_valid = c_valid[k+1];
            assign right_value = c_value[k+1];
            assign right_age   = c_age[k+1];
        end else begin : g_right_end
            assign right_valid = 1'b0;
            assign right_value = '0;
            assign right_age   = '0;
        end

        if (k > 0) begin : g_left
            assign left_kept = c_kept[k-1];
        end else begin : g_left_end
            assign left_kept = 1'b1;
        end

        swm_cell #(
            .AGE_W (AGE_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_left_kept   (left_kept),
            .i_right_valid (right_valid),
            .i_right_value (right_value),
            .i_right_age   (right_age),
            .o_valid       (c_valid[k]),
            .o_value       (c_value[k]),
            .o_age         (c_age[k]),
            .o_kept        (c_kept[k]),
            .o_next_value  (c_next_value[k])
        );
    end

    // Window size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WS_RESET;
        end else if (i_cfg_wr_en) begin
            r_window_size <= i_cfg_wr_data;
        end
    end

    // Track the pending sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (do_commit) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample_value;
            r_first  <= i_first_sample;
            r_last   <= i_last_sample;
        end
    end

    // Advance position and full flag on each committed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_full <= 1'b0;
        end else if (do_commit) begin
            r_pos  <= pos + VALUE_W'(1);
            r_full <= produce || (!r_first && r_full);
        end
    end

    // Result register: load on commit, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_commit) begin
            r_out_valid <= produce;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_commit && produce) begin
            r_out_max  <= c_next_value[0];
            r_out_last <= r_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_window_max  = r_out_max;
    assign o_last_result = r_out_last;

endmodule

// File: rtl/swm_checker.sv
// Port-level checks for the sliding window maximum block, bound to the top level.
module swm_checker
    import swm_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [VALUE_W-1:0] o_window_max,
    input logic                      o_last_result
);

    // Result stays offered while stalled
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Stalled result does not change
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_window_max) && $stable(o_last_result))
        else $error("result changed while stalled");

    // Reset leaves no result and an open input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // A new result needs a sample that was transferred or pending before it
    a_out_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall || i_in_valid, 2))
        else $error("result without a sample");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_window_max  (o_window_max),
    .o_last_result (o_last_result)
);
